// ----- rtl/core/mpq_pkg.sv -----
package mpq_pkg;

  localparam int ARRAY_SLOTS = 16;
  // one slot of the store is never used, so the chain holds one fewer
  localparam int NUM_CELLS   = ARRAY_SLOTS - 1;
  localparam int COUNT_W     = $clog2(NUM_CELLS + 1);
  localparam int DATA_W      = 32;
  localparam int ECOUNT_W    = 4;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } in_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  removed_value;
    logic                      top_valid;
    logic signed [DATA_W-1:0]  top_value;
    logic [ECOUNT_W-1:0]       entry_count;
  } out_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic signed [DATA_W-1:0]  value;
  } nb_t;

  // broadcast to every cell
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage

// ----- rtl/core/mpq_cell.sv -----
module mpq_cell
  import mpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  nb_t       left,
  input  logic      left_take,
  input  nb_t       right,
  output nb_t       own,
  output logic      take
);

  logic                     valid;
  logic signed [DATA_W-1:0] value;

  // an empty cell counts as smaller than anything
  assign take = !valid || (ctl.value > value);
  assign own  = '{valid: valid, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.rem) begin
      valid <= right.valid;
    end else if (ctl.ins && take) begin
      valid <= left_take ? left.valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rem) begin
      value <= right.value;
    end else if (ctl.ins && take) begin
      value <= left_take ? left.value : ctl.value;
    end
  end

endmodule

// ----- rtl/core/max_priority_queue.sv -----
// a word taken while idle is held in pend with busy high; the compare and shift of the cell
// chain is done in a single step, registered in the cells together with result and done
// a new word is not taken while busy is high (busy is high for the cycle after start)
// reset: synchronous rst empties the queue; the receiver cannot stall, so done lasts one cycle
module max_priority_queue
  import mpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic done,
  output out_t result
);

  in_t                 pend;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  cell_ctl_t           ctl;
  nb_t                 cell_nb   [NUM_CELLS];
  logic                take      [NUM_CELLS];
  logic [NUM_CELLS-1:0] valid_vec;
  logic                is_full;
  logic                is_empty;
  out_t                res_next;

  assign is_full  = (count == COUNT_W'(NUM_CELLS));
  assign is_empty = (count == '0);

  always_comb begin
    ctl.ins   = busy && (pend.kind == KIND_INSERT) && !is_full;
    ctl.rem   = busy && (pend.kind == KIND_REMOVE) && !is_empty;
    ctl.value = pend.value;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    nb_t  left_nb;
    nb_t  right_nb;
    logic left_take;
    if (i == 0) begin : g_first
      assign left_nb   = '{valid: 1'b0, value: '0};
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left_nb   = cell_nb[i-1];
      assign left_take = take[i-1];
    end
    if (i == NUM_CELLS - 1) begin : g_last
      assign right_nb = '{valid: 1'b0, value: '0};
    end else begin : g_inner
      assign right_nb = cell_nb[i+1];
    end
    mpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (left_nb),
      .left_take (left_take),
      .right     (right_nb),
      .own       (cell_nb[i]),
      .take      (take[i])
    );
    assign valid_vec[i] = cell_nb[i].valid;
  end

  always_comb begin
    count_next = count;
    res_next   = '0;
    res_next.status = ST_DONE;
    if (pend.kind == KIND_INSERT) begin
      if (is_full) begin
        res_next.status    = ST_FULL;
        res_next.top_value = cell_nb[0].value;
      end else begin
        count_next         = count + 1'b1;
        res_next.top_value = take[0] ? pend.value : cell_nb[0].value;
      end
    end else begin
      if (is_empty) begin
        res_next.status = ST_EMPTY;
      end else begin
        count_next             = count - 1'b1;
        res_next.removed_value = cell_nb[0].value;
        // the second cell moves up to the head
        if (NUM_CELLS > 1) begin
          res_next.top_value = cell_nb[NUM_CELLS > 1 ? 1 : 0].value;
        end
      end
    end
    res_next.top_valid   = (count_next != '0);
    if (count_next == '0) begin
      res_next.top_value = '0;
    end
    res_next.entry_count = ECOUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy;
      if (busy) begin
        busy  <= 1'b0;
        count <= count_next;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pend <= item;
    end
    if (busy) begin
      result <= res_next;
    end
  end

  // occupied cells always match the entry count
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell occupancy differs from entry count");

  assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(NUM_CELLS))
    else $error("entry count beyond capacity");

  // head cell is at least the second cell whenever the second cell is occupied
  assert property (@(posedge clk) disable iff (rst)
    cell_nb[NUM_CELLS > 1 ? 1 : 0].valid |->
      (cell_nb[0].value >= cell_nb[NUM_CELLS > 1 ? 1 : 0].value))
    else $error("head cell is not the maximum");

  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result without a word in flight");

endmodule
